FILE: rtl/ppiu_pkg.sv
// Shared constants, codes and types for the paletted packed index unpacker.
`default_nettype none

package ppiu_pkg;

    // Section geometry and storage sizes
    localparam int SECTION_DIM    = 16;
    localparam int PALETTE_DEPTH  = 256;
    localparam int MAX_ENTRY_BITS = 16;
    localparam int MIN_ENTRY_BITS = 4;
    localparam int WORD_BITS      = 64;
    localparam int VALUE_SHIFT    = 4;
    localparam int TOTAL_ENTRIES  = SECTION_DIM * SECTION_DIM * SECTION_DIM;

    // Field and counter widths
    localparam int COORD_W     = $clog2(SECTION_DIM);
    localparam int ENTRY_NUM_W = 3 * COORD_W;
    localparam int ENTRY_CNT_W = ENTRY_NUM_W + 1;
    localparam int IDX_W       = MAX_ENTRY_BITS;
    localparam int PAL_AW      = $clog2(PALETTE_DEPTH);
    localparam int PAL_DW      = 16;
    localparam int VALUE_W     = 12;
    localparam int WIDTH_W     = 5;
    localparam int PLEN_W      = 9;
    localparam int CFG_DW      = 9;
    localparam int WPOS_W      = 10;
    localparam int BPOS_W      = $clog2(WORD_BITS);
    localparam int POS_W       = BPOS_W + 1;
    localparam int CARRY_CNT_W = $clog2(MAX_ENTRY_BITS);
    localparam int CARRY_W     = MAX_ENTRY_BITS - 1;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 48;

    // Input item kinds
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_DATA_WORD     = 1'b1;

    // Configuration register indexes
    localparam logic REG_BITS_PER_ENTRY = 1'b0;
    localparam logic REG_PALETTE_LENGTH = 1'b1;

    // One decoded entry leaving the extractor
    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        logic [ENTRY_NUM_W-1:0] entry_num;
        logic [WPOS_W-1:0]      wpos;
        logic [BPOS_W-1:0]      bpos;
        logic                   straddles;
        logic                   done;
        logic                   last;
    } entry_t;

    // Palette write request
    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] slot;
        logic [PAL_DW-1:0] data;
    } pal_wr_t;

    // Result word fields, lowest first at the bottom
    typedef struct packed {
        logic [OUT_DATA_W-44:0] pad;
        logic                   section_done;
        logic                   index_error;
        logic                   straddles;
        logic [BPOS_W-1:0]      bit_position;
        logic [WPOS_W-1:0]      word_position;
        logic [COORD_W-1:0]     pos_x;
        logic [COORD_W-1:0]     pos_z;
        logic [COORD_W-1:0]     pos_y;
        logic [VALUE_W-1:0]     block_value;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/ppiu_unpack.sv
// Word register and index extractor with carry, one entry per cycle unless stalled.
`default_nettype none

module ppiu_unpack (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_op,
    input  wire logic [ppiu_pkg::PAL_AW-1:0]    in_slot,
    input  wire logic [ppiu_pkg::PAL_DW-1:0]    in_pal_entry,
    input  wire logic [ppiu_pkg::WORD_BITS-1:0] in_word,
    input  wire logic [ppiu_pkg::WIDTH_W-1:0]   bits_per_entry,
    input  wire logic                           advance,
    output logic                                ent_valid,
    output ppiu_pkg::entry_t                    ent,
    output ppiu_pkg::pal_wr_t                   pal_wr
);

    localparam logic [ppiu_pkg::ENTRY_CNT_W-1:0] TOTAL =
        ppiu_pkg::ENTRY_CNT_W'(ppiu_pkg::TOTAL_ENTRIES);
    localparam logic [ppiu_pkg::POS_W-1:0] WORD_END =
        ppiu_pkg::POS_W'(ppiu_pkg::WORD_BITS);

    // Control state
    logic                                busy_reg;
    logic                                start_reg;
    logic [ppiu_pkg::POS_W-1:0]          pos_reg;
    logic [ppiu_pkg::CARRY_W-1:0]        carry_bits_reg;
    logic [ppiu_pkg::CARRY_CNT_W-1:0]    carry_cnt_reg;
    logic [ppiu_pkg::ENTRY_CNT_W-1:0]    entry_cnt_reg;
    logic [ppiu_pkg::WPOS_W-1:0]         word_cnt_reg;

    // Held word
    logic                                op_reg;
    logic [ppiu_pkg::PAL_AW-1:0]         slot_reg;
    logic [ppiu_pkg::PAL_DW-1:0]         pal_entry_reg;
    logic [ppiu_pkg::WORD_BITS-1:0]      word_reg;

    logic [ppiu_pkg::WIDTH_W-1:0]        width;
    logic [ppiu_pkg::IDX_W-1:0]          mask;
    logic                                is_word;
    logic                                sec_full;
    logic                                carry_ok;
    logic                                strad;
    logic [ppiu_pkg::POS_W-1:0]          base_pos;
    logic [ppiu_pkg::WORD_BITS-1:0]      shifted;
    logic [ppiu_pkg::IDX_W-1:0]          strad_idx;
    logic [ppiu_pkg::WIDTH_W-1:0]        need;
    logic [ppiu_pkg::POS_W-1:0]          next_pos;
    logic [ppiu_pkg::POS_W:0]            next_end;
    logic [ppiu_pkg::ENTRY_CNT_W-1:0]    cnt_after;
    logic                                more;
    logic                                step;
    logic                                finish;
    logic                                accept;
    logic [ppiu_pkg::WORD_BITS-1:0]      rest;
    logic [ppiu_pkg::POS_W-1:0]          rest_cnt;
    logic [ppiu_pkg::POS_W-1:0]          strad_bpos;

    // Clamp the entry width to its legal range
    always_comb
    begin
        if (bits_per_entry < ppiu_pkg::WIDTH_W'(ppiu_pkg::MIN_ENTRY_BITS))
        begin
            width = ppiu_pkg::WIDTH_W'(ppiu_pkg::MIN_ENTRY_BITS);
        end
        else if (bits_per_entry > ppiu_pkg::WIDTH_W'(ppiu_pkg::MAX_ENTRY_BITS))
        begin
            width = ppiu_pkg::WIDTH_W'(ppiu_pkg::MAX_ENTRY_BITS);
        end
        else
        begin
            width = bits_per_entry;
        end
    end

    assign mask = ~({ppiu_pkg::IDX_W{1'b1}} << width);

    // Pick the entry to extract this cycle: straddling entry first, then in-word entries
    assign is_word   = busy_reg && (op_reg == ppiu_pkg::OP_DATA_WORD);
    assign sec_full  = (entry_cnt_reg == TOTAL);
    assign carry_ok  = (carry_cnt_reg != '0)
                       && ({1'b0, carry_cnt_reg} < width);
    assign strad     = start_reg && carry_ok;
    assign base_pos  = start_reg ? '0 : pos_reg;
    assign shifted   = word_reg >> base_pos[ppiu_pkg::BPOS_W-1:0];
    assign strad_idx = ({1'b0, carry_bits_reg}
                        | (word_reg[ppiu_pkg::IDX_W-1:0] << carry_cnt_reg)) & mask;
    assign need      = width - {1'b0, carry_cnt_reg};
    assign next_pos  = strad ? ppiu_pkg::POS_W'(need)
                             : base_pos + ppiu_pkg::POS_W'(width);
    assign next_end  = {1'b0, next_pos} + (ppiu_pkg::POS_W+1)'(width);
    assign cnt_after = entry_cnt_reg + 1'b1;
    assign more      = (next_end <= {1'b0, WORD_END}) && (cnt_after != TOTAL);
    assign strad_bpos = WORD_END - ppiu_pkg::POS_W'(carry_cnt_reg);

    // Leftover bits at the top of the word
    assign rest     = word_reg >> next_pos[ppiu_pkg::BPOS_W-1:0];
    assign rest_cnt = WORD_END - next_pos;

    assign ent_valid = is_word && !sec_full;
    assign step      = ent_valid && advance;
    assign finish    = busy_reg && ((op_reg == ppiu_pkg::OP_PALETTE_WRITE)
                                    || (is_word && sec_full)
                                    || (step && !more));
    assign in_ready  = !busy_reg || finish;
    assign accept    = in_valid && in_ready;

    // Entry description
    always_comb
    begin
        ent.idx       = strad ? strad_idx : (shifted[ppiu_pkg::IDX_W-1:0] & mask);
        ent.entry_num = entry_cnt_reg[ppiu_pkg::ENTRY_NUM_W-1:0];
        ent.wpos      = strad ? (word_cnt_reg - 1'b1) : word_cnt_reg;
        ent.bpos      = strad ? strad_bpos[ppiu_pkg::BPOS_W-1:0]
                              : base_pos[ppiu_pkg::BPOS_W-1:0];
        ent.straddles = strad;
        ent.done      = (cnt_after == TOTAL);
        ent.last      = !more;
    end

    // Palette write is driven straight from the word register
    assign pal_wr.en   = busy_reg && (op_reg == ppiu_pkg::OP_PALETTE_WRITE);
    assign pal_wr.slot = slot_reg;
    assign pal_wr.data = pal_entry_reg;

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            pos_reg        <= '0;
            carry_bits_reg <= '0;
            carry_cnt_reg  <= '0;
            entry_cnt_reg  <= '0;
            word_cnt_reg   <= '0;
        end
        else
        begin
            if (step)
            begin
                start_reg     <= 1'b0;
                pos_reg       <= next_pos;
                entry_cnt_reg <= cnt_after;
                if (!more)
                begin
                    word_cnt_reg <= word_cnt_reg + 1'b1;
                    if ((cnt_after != TOTAL) && (next_pos < WORD_END))
                    begin
                        carry_bits_reg <= rest[ppiu_pkg::CARRY_W-1:0];
                        carry_cnt_reg  <= rest_cnt[ppiu_pkg::CARRY_CNT_W-1:0];
                    end
                    else
                    begin
                        carry_bits_reg <= '0;
                        carry_cnt_reg  <= '0;
                    end
                end
            end
            if (accept)
            begin
                busy_reg  <= 1'b1;
                start_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= in_op;
            slot_reg      <= in_slot;
            pal_entry_reg <= in_pal_entry;
            word_reg      <= in_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/paletted_packed_index_unpacker.sv
// Top level: config registers, palette memory, lookup stage and result register.
// A word's results pass the word register, lookup stage and result register to m_axis.
// Results leave at one per cycle while m_axis_tready allows; a data word holds the
// extractor until each entry it completes (16 at width 4, 4 at width 16) has left it.
// The rate is set by the single entry extractor feeding the one-read palette memory.
// Reset clears counters, carry and result valid, and loads width 4, palette length 0;
// palette contents are undefined until written.
`default_nettype none

module paletted_packed_index_unpacker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [ppiu_pkg::CFG_DW-1:0]      cfg_data,
    // Input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // palette_slot[7:0], palette_entry[23:8], packed_word[87:24]
    input  wire logic [ppiu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  wire logic                             s_axis_tuser,
    // Result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // block_value[11:0], pos_y[15:12], pos_z[19:16], pos_x[23:20],
    // word_position[33:24], bit_position[39:34], straddles[40],
    // index_error[41], section_done[42], zero[47:43]
    output logic [ppiu_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int NC = ppiu_pkg::COORD_W;

    logic [ppiu_pkg::WIDTH_W-1:0]  bits_per_entry_reg;
    logic [ppiu_pkg::PLEN_W-1:0]   palette_length_reg;

    logic                          advance;
    logic                          ent_valid;
    ppiu_pkg::entry_t              ent;
    ppiu_pkg::pal_wr_t             pal_wr;

    logic [ppiu_pkg::PAL_DW-1:0]   palette_mem [ppiu_pkg::PALETTE_DEPTH];
    logic [ppiu_pkg::PAL_DW-1:0]   pal_rd_reg;

    logic                          s2_valid_reg;
    ppiu_pkg::entry_t              s2_ent_reg;

    logic                          out_valid_reg;
    ppiu_pkg::result_t             out_data_reg;
    logic                          out_last_reg;
    ppiu_pkg::result_t             out_data_next;

    logic                          in_range;
    logic                          idx_err;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_per_entry_reg <= ppiu_pkg::WIDTH_W'(ppiu_pkg::MIN_ENTRY_BITS);
            palette_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppiu_pkg::REG_BITS_PER_ENTRY:
                    bits_per_entry_reg <= cfg_data[ppiu_pkg::WIDTH_W-1:0];
                ppiu_pkg::REG_PALETTE_LENGTH:
                    palette_length_reg <= cfg_data[ppiu_pkg::PLEN_W-1:0];
                default:
                    palette_length_reg <= palette_length_reg;
            endcase
        end
    end

    // The whole pipeline moves when the result register can take a word
    assign advance = !out_valid_reg || m_axis_tready;

    ppiu_unpack u_unpack (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_op          (s_axis_tuser),
        .in_slot        (s_axis_tdata[7:0]),
        .in_pal_entry   (s_axis_tdata[23:8]),
        .in_word        (s_axis_tdata[87:24]),
        .bits_per_entry (bits_per_entry_reg),
        .advance        (advance),
        .ent_valid      (ent_valid),
        .ent            (ent),
        .pal_wr         (pal_wr)
    );

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pal_wr.en)
        begin
            palette_mem[pal_wr.slot] <= pal_wr.data;
        end
        if (ent_valid && advance)
        begin
            pal_rd_reg <= palette_mem[ent.idx[ppiu_pkg::PAL_AW-1:0]];
        end
    end

    // Lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= ent_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ent_valid)
        begin
            s2_ent_reg <= ent;
        end
    end

    // Resolve value and range error
    assign in_range = ({{(ppiu_pkg::IDX_W-ppiu_pkg::PLEN_W){1'b0}}, palette_length_reg}
                       > s2_ent_reg.idx)
                      && (s2_ent_reg.idx[ppiu_pkg::IDX_W-1:ppiu_pkg::PAL_AW] == '0);
    assign idx_err  = (palette_length_reg != '0) && !in_range;

    always_comb
    begin
        out_data_next = '0;
        if (palette_length_reg == '0)
        begin
            out_data_next.block_value = s2_ent_reg.idx[ppiu_pkg::IDX_W-1:ppiu_pkg::VALUE_SHIFT];
        end
        else if (!idx_err)
        begin
            out_data_next.block_value = pal_rd_reg[ppiu_pkg::PAL_DW-1:ppiu_pkg::VALUE_SHIFT];
        end
        out_data_next.pos_y         = s2_ent_reg.entry_num[3*NC-1:2*NC];
        out_data_next.pos_z         = s2_ent_reg.entry_num[2*NC-1:NC];
        out_data_next.pos_x         = s2_ent_reg.entry_num[NC-1:0];
        out_data_next.word_position = s2_ent_reg.wpos;
        out_data_next.bit_position  = s2_ent_reg.bpos;
        out_data_next.straddles     = s2_ent_reg.straddles;
        out_data_next.index_error   = idx_err;
        out_data_next.section_done  = s2_ent_reg.done;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s2_ent_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/ppiu_checker.sv
// Port-level checks on the unpacker's result stream, bound to the top level.
`default_nettype none

module ppiu_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic                             cfg_index,
    input wire logic [ppiu_pkg::CFG_DW-1:0]      cfg_data,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [ppiu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [ppiu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire logic                             m_axis_tlast
);

    // No result shows while reset is held
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The final entry of a section sits at the far corner and ends its word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[42] |-> (m_axis_tdata[23:12] == 12'hFFF) && m_axis_tlast)
        else $error("section end at wrong position or not last of word");

    // A straddling entry never starts at bit zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[40] |-> (m_axis_tdata[39:34] != 6'd0))
        else $error("straddling entry starts at bit zero");

    // An out-of-range palette index yields a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[41] |-> (m_axis_tdata[11:0] == 12'd0))
        else $error("index error with nonzero value");

endmodule

bind paletted_packed_index_unpacker ppiu_checker u_ppiu_checker (.*);

`default_nettype wire
